/* rtl/socks5_client_connect_assert.svh */
// Assertion macros shared by the SOCKS5 client connect RTL.
`ifndef SOCKS5_CLIENT_CONNECT_ASSERT_SVH
`define SOCKS5_CLIENT_CONNECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S5CC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define S5CC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/s5cc_pkg.sv */
// Types and protocol constants for the SOCKS5 client connect block.
package s5cc_pkg;

    // SOCKS5 protocol bytes
    localparam logic [7:0] SOCKS_VERSION   = 8'd5;
    localparam logic [7:0] NUM_METHODS     = 8'd1;
    localparam logic [7:0] NO_AUTH         = 8'd0;
    localparam logic [7:0] CMD_CONNECT     = 8'd1;
    localparam logic [7:0] RSV_BYTE        = 8'd0;
    localparam logic [7:0] REPLY_SUCCEEDED = 8'd0;
    localparam logic [7:0] ATYP_IPV4       = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN     = 8'd3;
    localparam logic [7:0] ATYP_IPV6       = 8'd4;

    // Bytes left in the reply after the first byte past the address type byte
    localparam logic [8:0] SKIP_IPV4       = 9'd5;
    localparam logic [8:0] SKIP_IPV6       = 9'd17;
    localparam logic [8:0] SKIP_DOMAIN_ADD = 9'd2;

    // Request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_RX    = 2'd1;
    localparam logic [1:0] REQ_HOST  = 2'd2;

    // Result kinds
    localparam logic OUT_BYTE   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HELLO  = 3'd1;
    localparam logic [2:0] ST_REQ_FAILED = 3'd2;
    localparam logic [2:0] ST_BAD_ATYPE  = 3'd3;
    localparam logic [2:0] ST_SEQUENCE   = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PORT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_LENGTH = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Longest result burst of one item and the count width
    localparam int BURST_DEPTH = 7;
    localparam int CNT_W       = $clog2(BURST_DEPTH + 1);

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [7:0] host_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic       last;
    } t_out_item;

endpackage

/* rtl/socks5_client_connect.sv */
// SOCKS5 client CONNECT handshake engine (domain name, no authentication).
//
// Usage: configure dest_port (index 0) and host_length (index 1) over the
// cfg channel while the block is idle. Send a start item on the input
// channel; the block emits the client hello, then checks each server byte,
// emits the connect request header, forwards host name bytes, appends the
// port, parses the reply header, skips the bound address and ends with one
// final status result. Every result of an item carries last on its final one.
// Timing: an accepted item updates the handshake state in the same edge and
// loads its whole result burst (0 to 7 results) into an output register
// array; the first result is valid the next cycle, one result per cycle
// after that while the receiver is ready. Items that give zero or one result
// are accepted every cycle while the receiver is ready; an item that gives
// more results holds off the next item as the single output port drains it.
// When the receiver stalls, the burst holds and input ready stays low while
// any result is pending; it rises as the final result leaves.
// Reset clears the state to idle, empties the burst and clears both config
// registers to zero. Config writes are always ready.
`include "socks5_client_connect_assert.svh"

module socks5_client_connect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  s5cc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output s5cc_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [s5cc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [s5cc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import s5cc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HELLO,
        PH_HOST,
        PH_REPLY,
        PH_SKIP
    } t_phase;

    // Configuration
    logic [15:0] r_dest_port, n_dest_port;
    logic [7:0]  r_host_length, n_host_length;

    // Handshake state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_host_sent, n_host_sent;
    logic [8:0]  r_skip_left, n_skip_left;
    logic        r_reply_bad, n_reply_bad;
    logic [7:0]  r_addr_type, n_addr_type;

    // Result burst register
    t_out_item             r_buf [BURST_DEPTH];
    t_out_item             n_buf [BURST_DEPTH];
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Burst produced by the current input item
    t_out_item             item_buf [BURST_DEPTH];
    logic [CNT_W-1:0]      item_cnt;

    logic        in_acc;
    logic        out_pop;
    logic        cfg_acc;
    logic [2:0]  hdr_inc;
    logic        bad_now;
    logic [7:0]  host_inc;
    logic [8:0]  skip_dec;

    function automatic t_out_item mk_byte(input logic [7:0] b);
        t_out_item r;
        r          = '0;
        r.out_kind = OUT_BYTE;
        r.tx_byte  = b;
        return r;
    endfunction

    function automatic t_out_item mk_status(input logic [2:0] st);
        t_out_item r;
        r          = '0;
        r.out_kind = OUT_STATUS;
        r.status   = st;
        return r;
    endfunction

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign o_out_valid = (r_cnt != '0);
    assign out_pop     = o_out_valid & i_out_ready;
    assign o_in_ready  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);
    assign in_acc      = i_in_valid & o_in_ready;

    // Head of the burst; last marks the final result of the item
    always_comb begin
        o_out_item      = r_buf[0];
        o_out_item.last = (r_cnt == CNT_W'(1));
    end

    // Configuration writes
    always_comb begin
        n_dest_port   = r_dest_port;
        n_host_length = r_host_length;
        if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_DEST_PORT:   n_dest_port   = i_cfg_data;
                CFG_HOST_LENGTH: n_host_length = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Per-item next state and result burst
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_host_sent = r_host_sent;
        n_skip_left = r_skip_left;
        n_reply_bad = r_reply_bad;
        n_addr_type = r_addr_type;
        item_buf    = '{default: '0};
        item_cnt    = '0;
        hdr_inc     = 3'(r_hdr_cnt + 3'd1);
        host_inc    = 8'(r_host_sent + 8'd1);
        skip_dec    = 9'(r_skip_left - 9'd1);
        bad_now     = 1'b0;

        unique case (i_in_item.req_type)
            REQ_START: begin
                if (r_phase != PH_IDLE) begin
                    item_buf[0] = mk_status(ST_SEQUENCE);
                    item_cnt    = CNT_W'(1);
                    n_phase     = PH_IDLE;
                end else begin
                    // client hello: version, one method, no auth
                    item_buf[0] = mk_byte(SOCKS_VERSION);
                    item_buf[1] = mk_byte(NUM_METHODS);
                    item_buf[2] = mk_byte(NO_AUTH);
                    item_cnt    = CNT_W'(3);
                    n_phase     = PH_HELLO;
                    n_hdr_cnt   = '0;
                    n_reply_bad = 1'b0;
                end
            end
            REQ_RX: begin
                unique case (r_phase)
                    PH_HELLO: begin
                        bad_now = (r_hdr_cnt == '0) ? (i_in_item.rx_byte != SOCKS_VERSION)
                                                    : (i_in_item.rx_byte != NO_AUTH);
                        n_reply_bad = r_reply_bad | bad_now;
                        n_hdr_cnt   = hdr_inc;
                        if (hdr_inc >= 3'd2) begin
                            if (n_reply_bad) begin
                                item_buf[0] = mk_status(ST_BAD_HELLO);
                                item_cnt    = CNT_W'(1);
                                n_phase     = PH_IDLE;
                            end else begin
                                // connect request header, domain address type
                                item_buf[0] = mk_byte(SOCKS_VERSION);
                                item_buf[1] = mk_byte(CMD_CONNECT);
                                item_buf[2] = mk_byte(RSV_BYTE);
                                item_buf[3] = mk_byte(ATYP_DOMAIN);
                                item_buf[4] = mk_byte(r_host_length);
                                item_cnt    = CNT_W'(5);
                                n_host_sent = '0;
                                n_hdr_cnt   = '0;
                                n_reply_bad = 1'b0;
                                if (r_host_length == '0) begin
                                    item_buf[5] = mk_byte(r_dest_port[15:8]);
                                    item_buf[6] = mk_byte(r_dest_port[7:0]);
                                    item_cnt    = CNT_W'(7);
                                    n_phase     = PH_REPLY;
                                end else begin
                                    n_phase = PH_HOST;
                                end
                            end
                        end
                    end
                    PH_REPLY: begin
                        if (r_hdr_cnt == 3'd0) begin
                            bad_now = (i_in_item.rx_byte != SOCKS_VERSION);
                        end else if (r_hdr_cnt == 3'd1) begin
                            bad_now = (i_in_item.rx_byte != REPLY_SUCCEEDED);
                        end
                        n_reply_bad = r_reply_bad | bad_now;
                        if (r_hdr_cnt == 3'd3) begin
                            n_addr_type = i_in_item.rx_byte;
                        end
                        if (r_hdr_cnt < 3'd4) begin
                            n_hdr_cnt = hdr_inc;
                        end else if (n_reply_bad) begin
                            item_buf[0] = mk_status(ST_REQ_FAILED);
                            item_cnt    = CNT_W'(1);
                            n_phase     = PH_IDLE;
                        end else begin
                            // remaining bound address length by type
                            n_hdr_cnt = '0;
                            n_phase   = PH_SKIP;
                            if (r_addr_type == ATYP_IPV4) begin
                                n_skip_left = SKIP_IPV4;
                            end else if (r_addr_type == ATYP_DOMAIN) begin
                                n_skip_left = 9'(i_in_item.rx_byte) + SKIP_DOMAIN_ADD;
                            end else if (r_addr_type == ATYP_IPV6) begin
                                n_skip_left = SKIP_IPV6;
                            end else begin
                                item_buf[0] = mk_status(ST_BAD_ATYPE);
                                item_cnt    = CNT_W'(1);
                                n_phase     = PH_IDLE;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip_left = skip_dec;
                        if (skip_dec == '0) begin
                            item_buf[0] = mk_status(ST_OK);
                            item_cnt    = CNT_W'(1);
                            n_phase     = PH_IDLE;
                        end
                    end
                    default: begin
                        // server byte while idle or sending the host name
                        item_buf[0] = mk_status(ST_SEQUENCE);
                        item_cnt    = CNT_W'(1);
                        n_phase     = PH_IDLE;
                    end
                endcase
            end
            REQ_HOST: begin
                if (r_phase != PH_HOST) begin
                    item_buf[0] = mk_status(ST_SEQUENCE);
                    item_cnt    = CNT_W'(1);
                    n_phase     = PH_IDLE;
                end else begin
                    item_buf[0] = mk_byte(i_in_item.host_byte);
                    item_cnt    = CNT_W'(1);
                    n_host_sent = host_inc;
                    // port follows once the count wraps or reaches the length
                    if ((host_inc == '0) || (host_inc >= r_host_length)) begin
                        item_buf[1] = mk_byte(r_dest_port[15:8]);
                        item_buf[2] = mk_byte(r_dest_port[7:0]);
                        item_cnt    = CNT_W'(3);
                        n_phase     = PH_REPLY;
                        n_hdr_cnt   = '0;
                        n_reply_bad = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // every return to idle clears the handshake context
        if (n_phase == PH_IDLE) begin
            n_hdr_cnt   = '0;
            n_host_sent = '0;
            n_skip_left = '0;
            n_reply_bad = 1'b0;
            n_addr_type = '0;
        end
    end

    // Burst register: shift out on pop, reload on a new item
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (out_pop) begin
            for (int i = 0; i < BURST_DEPTH - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = CNT_W'(r_cnt - CNT_W'(1));
        end
        if (in_acc) begin
            n_buf = item_buf;
            n_cnt = item_cnt;
        end
    end

    // Control state, configuration and burst payload
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_hdr_cnt     <= '0;
            r_host_sent   <= '0;
            r_skip_left   <= '0;
            r_reply_bad   <= 1'b0;
            r_addr_type   <= '0;
            r_cnt         <= '0;
            r_dest_port   <= '0;
            r_host_length <= '0;
        end else begin
            r_cnt         <= n_cnt;
            r_dest_port   <= n_dest_port;
            r_host_length <= n_host_length;
            if (in_acc) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_host_sent <= n_host_sent;
                r_skip_left <= n_skip_left;
                r_reply_bad <= n_reply_bad;
                r_addr_type <= n_addr_type;
            end
        end
    end

    // Checks
    `S5CC_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= CNT_W'(BURST_DEPTH), "burst count out of range")
    `S5CC_ASSERT_NOW(a_status_alone, i_clk, i_rst_n,
        o_out_valid && (o_out_item.out_kind == OUT_STATUS),
        r_cnt == CNT_W'(1), "status result is not the last of its burst")
    `S5CC_ASSERT_NEXT(a_start_hello, i_clk, i_rst_n,
        in_acc && (i_in_item.req_type == REQ_START) && (r_phase == PH_IDLE),
        (r_phase == PH_HELLO) && (r_cnt == CNT_W'(3)), "start did not open the hello")
    `S5CC_ASSERT_NOW(a_skip_live, i_clk, i_rst_n, r_phase == PH_SKIP,
        r_skip_left != '0, "skip phase with nothing left to skip")

endmodule
